// ----- hw/rtl/signed_int_to_decimal_ascii_top_defines.svh -----
// Assertion macros used by the top level of the decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIDTA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SIDTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/sidta_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sidta_pkg;

  localparam int unsigned CharW = 6;
  localparam logic [CharW-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CharW-1:0] ASCII_MINUS = 6'd45;
  localparam logic [CharW-1:0] ASCII_NINE  = 6'd57;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic busy;
    logic load;
    logic convert;
    logic sign;
    logic digit;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic neg;
    logic skip;
    logic last;
  } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/signed_int_to_decimal_ascii_top.sv -----
// Signed integer to decimal ASCII text.
// Input: value_i is taken at a rising edge where start_i is high and busy_o is low.
// Output: one character per word on character_o / is_last_o, marked by valid_o
// for exactly one cycle; '-' leads for negative values, no leading zeros, a
// zero gives a single '0', and is_last_o flags the final digit of the number.
// Sequence: after acceptance the magnitude is converted to BCD by a
// shift-and-add-3 loop, one input bit per cycle. Then the sign is emitted if
// present, and the digit sweep steps through the BCD positions (10 positions at
// DATA_WIDTH = 32, floor(W*log10 2)+1 in general); leading zero positions are
// dropped silently. Output is registered, so each character appears in the cycle
// after its sweep step. At DATA_WIDTH = 32 the bit-serial BCD loop takes most of
// the time from acceptance until busy_o falls.
// busy_o may fall while the last character is still on the output.
// Reset (rst_ni low, asynchronous) returns the block to idle and drops valid_o.
// The receiver cannot stall: every word must be taken in the cycle it is shown.
`timescale 1ns / 1ps
`default_nettype none
`include "signed_int_to_decimal_ascii_top_defines.svh"

module signed_int_to_decimal_ascii_top #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic [DATA_WIDTH-1:0]   value_i,
  output logic                         valid_o,
  output logic [sidta_pkg::CharW-1:0] character_o,
  output logic                         is_last_o
);
  import sidta_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sidta_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  sidta_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .character_o (character_o),
    .is_last_o   (is_last_o),
    .valid_o     (valid_o)
  );

  assign busy_o = cmd.busy;

  `SIDTA_ASSERT_IMP(a_char_legal, clk_i, rst_ni, valid_o,
    (character_o == ASCII_MINUS) || ((character_o >= ASCII_ZERO) && (character_o <= ASCII_NINE)),
    "character outside '-' and '0'..'9'")
  `SIDTA_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i && !busy_o,
    busy_o && !valid_o, "accepted word did not start conversion")
  `SIDTA_ASSERT_NEXT(a_last_gap, clk_i, rst_ni, valid_o && is_last_o,
    !valid_o, "word followed the last character directly")
  `SIDTA_ASSERT_IMP(a_minus_not_last, clk_i, rst_ni, valid_o && (character_o == ASCII_MINUS),
    !is_last_o, "minus sign flagged as last character")

endmodule

`default_nettype wire

// ----- hw/rtl/sidta_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sidta_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire sidta_pkg::sts_t sts_i,
  output sidta_pkg::cmd_t      cmd_o
);
  import sidta_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.busy   = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        if (sts_i.conv_done) begin
          state_d = sts_i.neg ? ST_SIGN : ST_EMIT;
        end else begin
          cmd_o.convert = 1'b1;
        end
      end
      ST_SIGN: begin
        cmd_o.sign = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.digit = 1'b1;
        if (sts_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sidta_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sidta_datapath #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [DATA_WIDTH-1:0]   value_i,
  input  wire sidta_pkg::cmd_t         cmd_i,
  output sidta_pkg::sts_t              sts_o,
  output logic [sidta_pkg::CharW-1:0] character_o,
  output logic                         is_last_o,
  output logic                         valid_o
);
  import sidta_pkg::*;

  // decimal digits needed for any DATA_WIDTH-bit magnitude
  localparam int unsigned NumDig = ((DATA_WIDTH * 1233) >> 12) + 1;
  localparam int unsigned BcdW   = NumDig * 4;
  localparam int unsigned CntW   = $clog2(DATA_WIDTH + 1);
  localparam int unsigned RemW   = $clog2(NumDig + 1);

  logic [DATA_WIDTH-1:0] mag_q, mag_d;
  logic [BcdW-1:0]       bcd_q, bcd_d, bcd_adj;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [RemW-1:0]       rem_q, rem_d;
  logic                  neg_q, neg_d;
  logic                  started_q, started_d;
  logic                  valid_q, valid_d;
  logic [CharW-1:0]      char_q, char_d;
  logic                  last_q, last_d;
  logic [3:0]            top_dig;

  assign top_dig = bcd_q[BcdW-1 -: 4];

  assign sts_o.conv_done = (cnt_q == CntW'(DATA_WIDTH));
  assign sts_o.neg       = neg_q;
  assign sts_o.last      = (rem_q == RemW'(1));
  assign sts_o.skip      = (top_dig == 4'd0) && !started_q && (rem_q != RemW'(1));

  // double dabble correction: every digit of five or more gets three added
  always_comb begin
    bcd_adj = bcd_q;
    for (int i = 0; i < NumDig; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    mag_d     = mag_q;
    bcd_d     = bcd_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    neg_d     = neg_q;
    started_d = started_q;
    valid_d   = 1'b0;
    char_d    = char_q;
    last_d    = last_q;
    if (cmd_i.load) begin
      neg_d     = value_i[DATA_WIDTH-1];
      mag_d     = value_i[DATA_WIDTH-1] ? (~value_i + DATA_WIDTH'(1)) : value_i;
      bcd_d     = '0;
      cnt_d     = '0;
      rem_d     = RemW'(NumDig);
      started_d = 1'b0;
    end
    if (cmd_i.convert) begin
      bcd_d = {bcd_adj[BcdW-2:0], mag_q[DATA_WIDTH-1]};
      mag_d = {mag_q[DATA_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q + CntW'(1);
    end
    if (cmd_i.sign) begin
      valid_d = 1'b1;
      char_d  = ASCII_MINUS;
      last_d  = 1'b0;
    end
    if (cmd_i.digit) begin
      bcd_d = {bcd_q[BcdW-5:0], 4'd0};
      rem_d = rem_q - RemW'(1);
      if (!sts_o.skip) begin
        valid_d   = 1'b1;
        char_d    = ASCII_ZERO + {2'd0, top_dig};
        last_d    = sts_o.last;
        started_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      rem_q     <= '0;
      neg_q     <= 1'b0;
      started_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      rem_q     <= rem_d;
      neg_q     <= neg_d;
      started_q <= started_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign character_o = char_q;
  assign is_last_o   = last_q;
  assign valid_o     = valid_q;

endmodule

`default_nettype wire
